[rtl/hsi_pkg.sv]
// hash set insert/lookup unit: shared types and constants
// payload structs for both channels, controller/datapath command and status
package hsi_pkg;

   localparam logic [31:0] HASH_MULT = 32'd2654435761;
   localparam logic [31:0] EMPTY_KEY = 32'hffff_ffff;
   localparam int POS_WIDTH = 10;
   localparam int COUNT_WIDTH = 11;

   localparam logic ACTION_INSERT = 1'b0;
   localparam logic ACTION_LOOKUP = 1'b1;

   typedef struct packed {
      logic        action;
      logic [31:0] key;
   } req_type;

   typedef struct packed {
      logic                   present;
      logic                   inserted;
      logic                   table_full;
      logic [POS_WIDTH-1:0]   insert_position;
      logic [COUNT_WIDTH-1:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic clear_step;
      logic load_slot;
      logic probe_step;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic probe_done;
   } status_type;

endpackage

[rtl/hsi_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module hsi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/hsi_datapath.sv]
// hash set datapath: key hashing, slot table, probe pointer, counters, result register
// depends on hsi_pkg and hsi_ram
module hsi_datapath #(
   parameter int HASH_BITS = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  hsi_pkg::req_type   req_data,
   input  hsi_pkg::cmd_type   cmd,
   output hsi_pkg::status_type status,
   output hsi_pkg::rsp_type   rsp_data
);

   localparam int SLOT_COUNT = 1 << HASH_BITS;
   localparam int CNT_BITS = HASH_BITS + 1;

   logic [31:0]          key_ff;
   logic                 action_ff;
   logic [31:0]          prod_ff;
   logic [HASH_BITS-1:0] slot_ff, slot_in;
   logic [HASH_BITS-1:0] probes_ff;
   logic [HASH_BITS-1:0] clr_addr_ff;
   logic [CNT_BITS-1:0]  count_ff;
   logic                 res_present_ff, res_inserted_ff, res_full_ff;
   logic [hsi_pkg::POS_WIDTH-1:0] res_pos_ff;
   hsi_pkg::rsp_type     rsp_data_ff;

   logic [31:0]          folded;
   logic [31:0]          prod_low;
   logic [31:0]          rd_data;
   logic                 hit, empty, exhausted, probe_done, do_insert;
   logic                 wr_en;
   logic [HASH_BITS-1:0] wr_addr;
   logic [31:0]          wr_data;
   logic [31:0]          count_wide;

   // all ones is the empty marker, so it shares a member with zero
   assign folded    = (req_data.key == hsi_pkg::EMPTY_KEY) ? 32'd0 : req_data.key;
   // only the low word of the product feeds the hash
   assign prod_low  = folded * hsi_pkg::HASH_MULT;

   assign hit        = (rd_data == key_ff);
   assign empty      = (rd_data == hsi_pkg::EMPTY_KEY);
   assign exhausted  = (probes_ff == {HASH_BITS{1'b1}});
   assign probe_done = hit | empty | exhausted;
   assign do_insert  = cmd.probe_step & empty & (action_ff == hsi_pkg::ACTION_INSERT);

   assign status.clear_last = (clr_addr_ff == {HASH_BITS{1'b1}});
   assign status.probe_done = probe_done;

   // read address is slot_in, the next value of slot_ff, so the registered rd_data always matches slot_ff
   always_comb begin
      slot_in = slot_ff;
      if (cmd.load_slot) begin
         slot_in = prod_ff[31 -: HASH_BITS];
      end else if (cmd.probe_step && !probe_done) begin
         slot_in = slot_ff + 1'b1;
      end
   end

   assign wr_en   = cmd.clear_step | do_insert;
   assign wr_addr = cmd.clear_step ? clr_addr_ff : slot_ff;
   assign wr_data = cmd.clear_step ? hsi_pkg::EMPTY_KEY : key_ff;

   hsi_ram #(
      .WIDTH (32),
      .DEPTH (SLOT_COUNT)
   ) u_slot_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (slot_in),
      .rd_data (rd_data)
   );

   assign count_wide = 32'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         count_ff    <= '0;
      end else begin
         if (cmd.clear_step) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
         if (do_insert) begin
            count_ff <= count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (cmd.start) begin
         key_ff    <= folded;
         action_ff <= req_data.action;
         prod_ff   <= prod_low;
      end
      if (cmd.load_slot) begin
         probes_ff <= '0;
      end else if (cmd.probe_step) begin
         probes_ff <= probes_ff + 1'b1;
      end
      if (cmd.probe_step && probe_done) begin
         res_present_ff  <= hit;
         res_inserted_ff <= do_insert;
         res_full_ff     <= !hit && !empty && (action_ff == hsi_pkg::ACTION_INSERT);
         res_pos_ff      <= do_insert ? count_wide[hsi_pkg::POS_WIDTH-1:0] : '0;
      end
      if (cmd.load_rsp) begin
         rsp_data_ff.present         <= res_present_ff;
         rsp_data_ff.inserted        <= res_inserted_ff;
         rsp_data_ff.table_full      <= res_full_ff;
         rsp_data_ff.insert_position <= res_pos_ff;
         rsp_data_ff.entry_count     <= count_wide[hsi_pkg::COUNT_WIDTH-1:0];
      end
   end

   assign rsp_data = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(SLOT_COUNT))
      else $error("stored key count above table size");

   a_insert_into_empty: assert property (@(posedge clock) disable iff (reset)
      (wr_en && !cmd.clear_step) |-> (rd_data == hsi_pkg::EMPTY_KEY))
      else $error("insert overwrote an occupied slot");

endmodule

[rtl/hsi_ctrl.sv]
// hash set controller: clearing pass, probe sequencing and channel handshakes
// depends on hsi_pkg
module hsi_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  hsi_pkg::status_type status,
   output hsi_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_ADDR  = 3'd2;
   localparam logic [2:0] ST_CHECK = 3'd3;
   localparam logic [2:0] ST_RESP  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_ADDR;
            end
         end
         ST_ADDR: begin
            cmd.load_slot = 1'b1;
            state_in      = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.probe_step = 1'b1;
            if (status.probe_done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            // output register free or being emptied by a transfer
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_accept_starts_probe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid) |=> (state_ff == ST_ADDR))
      else $error("accepted item did not start a probe");

   a_done_to_resp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK && status.probe_done) |=> (state_ff == ST_RESP))
      else $error("finished probe did not move to response");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> !$past(cmd.load_rsp))
      else $error("result loaded over a waiting result");

endmodule

[rtl/hash_set_insert_lookup_unit.sv]
// hash set insert/lookup unit, linear probing over a 2**HASH_BITS slot table.
// a request transfer loads the key, ST_ADDR sets the first slot, then ST_CHECK reads 1 to
// 2**HASH_BITS slots, one slot per cycle through the table's read port, and ST_RESP loads the
// result and rsp_valid once the output register is free; a new request waits for that load.
// reset: synchronous; afterwards a clearing pass writes the empty marker to every slot,
// with req_stall high throughout.
module hash_set_insert_lookup_unit #(
   parameter int HASH_BITS = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  hsi_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hsi_pkg::rsp_type rsp_data
);

   hsi_pkg::cmd_type    cmd;
   hsi_pkg::status_type status;

   hsi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   hsi_datapath #(
      .HASH_BITS (HASH_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule
